// File: rtl/spfa_pkg.sv
`default_nettype none
package spfa_pkg;
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        STEPS_INVALID   = 3'd1,
        STEPS_RANGE     = 3'd3,
        STEPS_OK        = 3'd4,
        STEPS_RND_OVF   = 3'd5,
        STEPS_RND_OK    = 3'd6
    } t_steps;

    // aligned operands passed from the align stage to the normalize stage
    typedef struct packed {
        logic        invalid;
        logic        sign_a;
        logic        sign_b;
        logic [7:0]  exp;
        logic [26:0] mag_a;
        logic [26:0] mag_b;
    } t_aligned;

    typedef struct packed {
        logic [31:0] sum_word;
        logic [1:0]  status;
        logic [2:0]  steps;
    } t_result;
endpackage
`default_nettype wire

// File: rtl/spfa_align.sv
`default_nettype none
module spfa_align
    import spfa_pkg::*;
(
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output t_aligned         o_al
);
    logic [7:0]  ea, eb, diff;
    logic [23:0] sa, sb;
    logic [26:0] ma, mb, big, sml, shifted;
    logic        a_small, sticky;
    logic [26:0] mask;

    // unpack; subnormals get exponent field 1
    always_comb begin
        ea = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        sa = {i_a[30:23] != 8'd0, i_a[22:0]};
        sb = {i_b[30:23] != 8'd0, i_b[22:0]};
        ma = {sa, 3'b000};
        mb = {sb, 3'b000};
        a_small = ea < eb;
        diff = a_small ? eb - ea : ea - eb;
        big = a_small ? mb : ma;
        sml = a_small ? ma : mb;
        // right shift with sticky
        if (diff > 8'd27) begin
            mask    = '0;
            shifted = 27'd0;
            sticky  = |sml;
        end else begin
            mask    = ~(27'h7FFFFFF << diff[4:0]);
            shifted = sml >> diff[4:0];
            sticky  = |(sml & mask);
        end
        o_al.invalid = (&i_a[30:23]) | (&i_b[30:23]);
        o_al.sign_a  = i_a[31];
        o_al.sign_b  = i_b[31];
        o_al.exp     = a_small ? eb : ea;
        o_al.mag_a   = a_small ? (shifted | {26'd0, sticky}) : big;
        o_al.mag_b   = a_small ? big : (shifted | {26'd0, sticky});
    end
endmodule
`default_nettype wire

// File: rtl/spfa_norm.sv
`default_nettype none
module spfa_norm
    import spfa_pkg::*;
(
    input  wire t_aligned i_al,
    output t_result       o_res
);
    logic [28:0] sa, sb, sum;
    logic        neg;
    logic [27:0] mag;
    logic [26:0] nm;
    logic [4:0]  lz;
    logic signed [10:0] e;
    logic [24:0] q;
    logic signed [10:0] e2;

    always_comb begin
        sa  = i_al.sign_a ? -{2'b00, i_al.mag_a} : {2'b00, i_al.mag_a};
        sb  = i_al.sign_b ? -{2'b00, i_al.mag_b} : {2'b00, i_al.mag_b};
        sum = sa + sb;
        neg = sum[28];
        mag = neg ? 28'(-sum) : sum[27:0];
        e   = 11'(signed'({3'b000, i_al.exp}));
        lz  = 5'd0;
        // carry out: one right shift keeping sticky
        if (mag[27]) begin
            nm = {mag[27:2], mag[1] | mag[0]};
            e  = e + 11'sd1;
        end else begin
            for (int i = 0; i < 27; i++) begin
                if (mag[i]) lz = 5'(26 - i);
            end
            nm = mag[26:0] << lz;
            e  = e - 11'(signed'({6'd0, lz}));
        end
        q  = {1'b0, nm[26:3]} + {24'd0, nm[2]};
        e2 = e + 11'sd1;
        o_res.sum_word = '0;
        o_res.status   = ST_OK;
        o_res.steps    = STEPS_OK;
        if (i_al.invalid) begin
            o_res.status = ST_INVALID;
            o_res.steps  = STEPS_INVALID;
        end else if (sum == 29'd0) begin
        end else if (e >= 11'sd255) begin
            o_res.status = ST_OVERFLOW;
            o_res.steps  = STEPS_RANGE;
        end else if (e <= 11'sd0) begin
            o_res.status = ST_UNDERFLOW;
            o_res.steps  = STEPS_RANGE;
        end else if (q[24]) begin
            if (e2 >= 11'sd255) begin
                o_res.status = ST_OVERFLOW;
                o_res.steps  = STEPS_RND_OVF;
            end else begin
                o_res.sum_word = {neg, e2[7:0], q[23:1]};
                o_res.steps    = STEPS_RND_OK;
            end
        end else begin
            o_res.sum_word = {neg, e[7:0], q[22:0]};
        end
    end
endmodule
`default_nettype wire

// File: rtl/single_precision_float_adder.sv
`default_nettype none
// Single-precision adder, stream in and stream out.
// s_axis: tdata carries operand_a in [31:0] and operand_b in [63:32].
// m_axis: tdata carries sum_word [31:0], status [33:32], steps_taken [36:34].
// Each accepted word passes the input register, then the result register.
// Throughput: one word per cycle while the receiver takes results.
// The operand pair is aligned and normalized/rounded in one combinational
// pass between the two registers.
// Reset clears both valid flags; no word is held afterwards.
// When the receiver stalls, the pipeline holds; s_axis_tready falls only
// when both registers are full and the result is not taken.
// Status: 0 ok, 1 invalid operand, 2 overflow, 3 underflow; the sum is
// zero unless status is ok. Results are never subnormal, rounding is
// to nearest with ties away from zero.
module single_precision_float_adder
    import spfa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // operand_a, operand_b
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [39:0] m_axis_tdata   // sum_word, status, steps_taken, pad
);
    logic        r_in_vld, r_out_vld;
    logic [63:0] r_in;
    t_result     r_out, n_out;
    t_aligned    al;
    logic        out_ready, in_ready;

    assign out_ready = !r_out_vld || m_axis_tready;
    assign in_ready  = !r_in_vld || out_ready;
    assign s_axis_tready = in_ready;

    spfa_align u_align (.i_a(r_in[31:0]), .i_b(r_in[63:32]), .o_al(al));
    spfa_norm  u_norm  (.i_al(al), .o_res(n_out));

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (in_ready && s_axis_tvalid) r_in <= s_axis_tdata;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= r_in_vld;
        end
        if (out_ready && r_in_vld) r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out.steps, r_out.status, r_out.sum_word};
endmodule
`default_nettype wire

// File: rtl/spfa_checker.sv
`default_nettype none
module spfa_sva
    import spfa_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    // result is held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // error status forces zero sum
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33:32] != ST_OK |-> m_axis_tdata[31:0] == 32'd0)
        else $error("nonzero sum with error status");
    // steps field is STEPS_INVALID when status is invalid
    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33:32] == ST_INVALID
        |-> m_axis_tdata[36:34] == STEPS_INVALID)
        else $error("invalid status with wrong step count");
    // input side always ready when output drains
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");
endmodule
bind single_precision_float_adder spfa_sva u_chk (.*);
`default_nettype wire
